// ===== hdl/fdt_pkg.sv =====
// Package for the file directory table: sizes, operation and status codes,
// the token that travels along the cell chain, and the name canonicalizer.
// No dependencies.
package fdt_pkg;

  localparam int ENTRIES    = 32;
  localparam int NAME_BYTES = 12;

  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int SLOT_W = 5;
  localparam int CMP_W  = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
  localparam int KEY_W  = 96;

  localparam logic [2:0] OP_LOOKUP = 3'd0;
  localparam logic [2:0] OP_ADD    = 3'd1;
  localparam logic [2:0] OP_DELETE = 3'd2;
  localparam logic [2:0] OP_READ   = 3'd3;
  localparam logic [2:0] OP_COUNT  = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  localparam logic [5:0] COUNT_MAX = 6'd63;

  typedef struct packed {
    logic        valid;
    logic [2:0]  op;
    logic [31:0] key_high;
    logic [63:0] key_low;
    logic [15:0] sector;
    logic [4:0]  slot;
    logic        done;
    logic [4:0]  found_slot;
    logic [15:0] sector_out;
    logic [5:0]  free_count;
  } token_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  found_slot;
    logic [15:0] sector_out;
    logic [5:0]  free_count;
  } result_t;

  // Low five bits of a cell index, zero extended first when the index is narrow.
  function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] idx);
    logic [CMP_W-1:0] w;
    w = CMP_W'(idx);
    return w[SLOT_W-1:0];
  endfunction

  // A name ends at its first zero byte; that byte, all later bytes and all
  // bytes at or past NAME_BYTES read as zero.
  function automatic logic [KEY_W-1:0] canon_name(input logic [31:0] hi,
                                                  input logic [63:0] lo);
    logic [KEY_W-1:0] w;
    logic [KEY_W-1:0] r;
    logic [7:0]       b;
    logic             alive;
    w     = {hi, lo};
    r     = '0;
    alive = 1'b1;
    for (int k = 0; k < 12; k++) begin
      b = w[KEY_W-1-8*k -: 8];
      if (k >= NAME_BYTES || b == 8'd0) begin
        alive = 1'b0;
      end
      if (alive) begin
        r[KEY_W-1-8*k -: 8] = b;
      end
    end
    return r;
  endfunction

endpackage

// ===== hdl/fdt_cell.sv =====
// One directory slot: stores a canonical name and a start sector, and applies
// the passing operation token to itself before handing it to the next cell.
// Depends on fdt_pkg.
module fdt_cell
  import fdt_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] cell_index,
  input  token_t           tok_in,
  output token_t           tok_out
);

  logic [31:0] name_high;
  logic [63:0] name_low;
  logic [15:0] sector;
  logic [31:0] name_high_next;
  logic [63:0] name_low_next;
  logic [15:0] sector_next;
  token_t      tok_next;

  logic name_match;
  logic slot_free;
  logic slot_hit;

  assign name_match = (name_high == tok_in.key_high) && (name_low == tok_in.key_low);
  assign slot_free  = (sector == 16'd0);
  assign slot_hit   = (CMP_W'(cell_index) == CMP_W'(tok_in.slot));

  always_comb begin
    tok_next       = tok_in;
    name_high_next = name_high;
    name_low_next  = name_low;
    sector_next    = sector;
    if (tok_in.valid) begin
      case (tok_in.op)
        OP_LOOKUP: begin
          if (!tok_in.done && name_match) begin
            tok_next.done       = 1'b1;
            tok_next.found_slot = to_slot(cell_index);
          end
        end
        OP_ADD: begin
          if (!tok_in.done && slot_free) begin
            tok_next.done       = 1'b1;
            tok_next.found_slot = to_slot(cell_index);
            name_high_next      = tok_in.key_high;
            name_low_next       = tok_in.key_low;
            sector_next         = tok_in.sector;
          end
        end
        OP_DELETE: begin
          if (slot_hit) begin
            name_high_next = '0;
            name_low_next  = '0;
            sector_next    = '0;
          end
        end
        OP_READ: begin
          if (slot_hit) begin
            tok_next.sector_out = sector;
          end
        end
        OP_COUNT: begin
          if (slot_free && tok_in.free_count != COUNT_MAX) begin
            tok_next.free_count = tok_in.free_count + 6'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      name_high <= '0;
      name_low  <= '0;
      sector    <= '0;
    end else begin
      name_high <= name_high_next;
      name_low  <= name_low_next;
      sector    <= sector_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out <= tok_next;
    end
  end

endmodule

// ===== hdl/file_directory_table.sv =====
// Top level of the file directory table: entry register, the chain of slot
// cells and the result stages. Depends on fdt_pkg and fdt_cell.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+--------------------------------------------
//   command  | cmd_valid / cmd_ready | op, name_high, name_low, sector_in, slot
//   result   | res_valid / res_ready | status, found_slot, sector_out, free_count
//
// Each command beat enters an entry register and then walks the cell chain,
// one slot per cycle, through the output register of each cell, then into the
// pending result register and from there into the output register.
// Only one command is in the chain at a time; the next one is accepted as soon
// as the previous result has moved into the output register, even while that
// result still waits for res_ready.
// Reset (synchronous, active high) clears every slot to a zero name and a
// zero sector, so all slots start free, and drops all valid flags.
module file_directory_table
  import fdt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  logic [2:0]  op,
  input  logic [31:0] name_high,
  input  logic [63:0] name_low,
  input  logic [15:0] sector_in,
  input  logic [4:0]  slot,
  output logic        res_valid,
  input  logic        res_ready,
  output logic [1:0]  status,
  output logic [4:0]  found_slot,
  output logic [15:0] sector_out,
  output logic [5:0]  free_count
);

  // tok[0] is the entry register; tok[i+1] is the output register of cell i.
  token_t           tok [0:ENTRIES];
  token_t           tok_entry;
  logic [KEY_W-1:0] key_canon;

  logic    busy;
  logic    pend_valid;
  result_t pend;
  result_t pend_next;
  result_t res;
  logic    cmd_take;
  logic    pend_move;

  assign cmd_ready = !busy;
  assign cmd_take  = cmd_valid && cmd_ready;
  // The finished result moves on when the output register is empty or drains.
  assign pend_move = pend_valid && (!res_valid || res_ready);

  // Keys are canonicalized once on entry; stored names are always canonical.
  assign key_canon = canon_name(name_high, name_low);

  always_comb begin
    tok_entry            = '0;
    tok_entry.valid      = 1'b1;
    tok_entry.op         = op;
    tok_entry.key_high   = key_canon[KEY_W-1 -: 32];
    tok_entry.key_low    = key_canon[63:0];
    tok_entry.sector     = sector_in;
    tok_entry.slot       = slot;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok[0].valid <= 1'b0;
    end else if (cmd_take) begin
      tok[0] <= tok_entry;
    end else begin
      tok[0].valid <= 1'b0;
    end
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    fdt_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cell_index (IDX_W'(i)),
      .tok_in     (tok[i]),
      .tok_out    (tok[i+1])
    );
  end

  // Turn the token leaving the last cell into a result. A lookup or add that
  // no cell claimed reports its failure status; unknown ops leave all zero.
  always_comb begin
    pend_next            = '0;
    pend_next.found_slot = tok[ENTRIES].found_slot;
    pend_next.sector_out = tok[ENTRIES].sector_out;
    pend_next.free_count = tok[ENTRIES].free_count;
    case (tok[ENTRIES].op)
      OP_LOOKUP: pend_next.status = tok[ENTRIES].done ? ST_OK : ST_NOT_FOUND;
      OP_ADD:    pend_next.status = tok[ENTRIES].done ? ST_OK : ST_FULL;
      default:   pend_next.status = ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (tok[ENTRIES].valid) begin
      pend <= pend_next;
    end
    if (pend_move) begin
      res <= pend;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      pend_valid <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      if (cmd_take) begin
        busy <= 1'b1;
      end else if (pend_move) begin
        busy <= 1'b0;
      end
      if (tok[ENTRIES].valid) begin
        pend_valid <= 1'b1;
      end else if (pend_move) begin
        pend_valid <= 1'b0;
      end
      if (pend_move) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  assign status     = res.status;
  assign found_slot = res.found_slot;
  assign sector_out = res.sector_out;
  assign free_count = res.free_count;

endmodule

// ===== dv/file_directory_table_test.sv =====
// Self-checking testbench for file_directory_table: directed and random command beats,
// with every result checked against a typed answer or a predictor of the slot table.
// Depends on fdt_pkg and the file_directory_table RTL.
`timescale 1ns / 1ps

module file_directory_table_test;
  import fdt_pkg::*;

  // Op encodings above OP_COUNT are unused; the block must answer them with all zeros.
  localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

  localparam int ITEMS_PER_PHASE = 230;
  localparam int PHASES          = 5;
  localparam int MAX_PRINTS      = 40;
  localparam int NAME_W          = 96;

  // One command beat as the sender drives it.
  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] name_high;
    logic [63:0] name_low;
    logic [15:0] sector;
    logic [4:0]  slot;
  } command_t;

  // A directed row: the command, and an answer typed in by hand when one is given.
  typedef struct packed {
    command_t cmd;
    logic     typed;
    result_t  answer;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        cmd_valid = 1'b0;
  logic        cmd_ready;
  logic [2:0]  op        = OP_LOOKUP;
  logic [31:0] name_high = '0;
  logic [63:0] name_low  = '0;
  logic [15:0] sector_in = '0;
  logic [4:0]  slot      = '0;
  logic        res_valid;
  logic        res_ready = 1'b0;
  logic [1:0]  status;
  logic [4:0]  found_slot;
  logic [15:0] sector_out;
  logic [5:0]  free_count;

  file_directory_table dut (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .op         (op),
    .name_high  (name_high),
    .name_low   (name_low),
    .sector_in  (sector_in),
    .slot       (slot),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .status     (status),
    .found_slot (found_slot),
    .sector_out (sector_out),
    .free_count (free_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  // Predicted contents of the directory: the trimmed name and start sector of each slot.
  logic [NAME_W-1:0] name_tab [ENTRIES];
  logic [15:0]       sector_tab [ENTRIES];

  // Results owed by the block, oldest first, and a pool of names that were added,
  // so that lookups hit often.
  result_t           owed_results [$];
  logic [NAME_W-1:0] added_names [$];
  directed_row_t     directed_rows [$];

  int      send_idle_pct = 0;
  int      stall_pct     = 0;
  int      hold_left     = 0;
  int      mismatches    = 0;
  int      results_seen  = 0;
  result_t oldest;

  // A name ends at its first zero byte, and nothing past NAME_BYTES counts. Find the
  // length of the live prefix and keep just that many bytes from the top.
  function automatic logic [NAME_W-1:0] trim_name(input logic [31:0] hi, input logic [63:0] lo);
    logic [NAME_W-1:0] raw;
    logic [NAME_W-1:0] all_ones;
    int                len;
    bit                ended;
    raw      = {hi, lo};
    all_ones = '1;
    len      = 0;
    ended    = 1'b0;
    for (int k = 0; k < NAME_BYTES && k < 12; k++) begin
      if (!ended && raw[NAME_W-1-8*k -: 8] != 8'h00) len++;
      else ended = 1'b1;
    end
    return raw & ~(all_ones >> (8 * len));
  endfunction

  function automatic int free_slots();
    int n;
    n = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (sector_tab[i] == 16'h0000) n++;
    end
    return n;
  endfunction

  // Applies one accepted command to the predicted directory and returns the answer.
  task automatic update_directory(input command_t c, output result_t r);
    logic [NAME_W-1:0] key;
    bit                hit;
    int                n;
    key = trim_name(c.name_high, c.name_low);
    r   = '0;
    hit = 1'b0;
    case (c.op)
      OP_LOOKUP: begin
        // Names only are compared, so a free slot with a matching name is a hit too.
        r.status = ST_NOT_FOUND;
        for (int i = 0; i < ENTRIES; i++) begin
          if (!hit && name_tab[i] == key) begin
            hit          = 1'b1;
            r.status     = ST_OK;
            r.found_slot = 5'(i);
          end
        end
      end
      OP_ADD: begin
        // A zero sector still writes the name, but the slot stays free.
        r.status = ST_FULL;
        for (int i = 0; i < ENTRIES; i++) begin
          if (!hit && sector_tab[i] == 16'h0000) begin
            hit           = 1'b1;
            name_tab[i]   = key;
            sector_tab[i] = c.sector;
            r.status      = ST_OK;
            r.found_slot  = 5'(i);
          end
        end
      end
      OP_DELETE: begin
        if (int'(c.slot) < ENTRIES) begin
          name_tab[c.slot]   = '0;
          sector_tab[c.slot] = '0;
        end
      end
      OP_READ: begin
        if (int'(c.slot) < ENTRIES) r.sector_out = sector_tab[c.slot];
      end
      OP_COUNT: begin
        n            = free_slots();
        r.free_count = (n > int'(COUNT_MAX)) ? COUNT_MAX : 6'(n);
      end
      default: begin
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= MAX_PRINTS) begin
      $display("%0t ns: result %0d, %s: got %0h, want %0h", $time, results_seen, what, got,
               want);
    end
  endtask

  // Drives one command beat, with a random idle gap first, and waits for acceptance.
  // The answer is worked out at the edge where the beat is taken. Valid is lowered
  // only for a gap, so it is never lowered and raised in one time step.
  task automatic send_command(input command_t c, input logic typed, input result_t answer);
    int      gap;
    result_t predicted;
    gap = 0;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    op        <= c.op;
    name_high <= c.name_high;
    name_low  <= c.name_low;
    sector_in <= c.sector;
    slot      <= c.slot;
    do @(posedge clk); while (!cmd_ready);
    update_directory(c, predicted);
    owed_results.push_back(typed ? answer : predicted);
  endtask

  // Sender pause: no beat is offered until every owed result has come back.
  task automatic drain_results();
    cmd_valid <= 1'b0;
    do @(posedge clk); while (owed_results.size() != 0);
  endtask

  function automatic directed_row_t row(input logic [2:0] o, input logic [31:0] hi,
                                        input logic [63:0] lo, input logic [15:0] sec,
                                        input logic [4:0] sl, input logic typed,
                                        input logic [1:0] st, input logic [4:0] fs,
                                        input logic [15:0] so, input logic [5:0] fc);
    directed_row_t d;
    d.cmd    = '{op: o, name_high: hi, name_low: lo, sector: sec, slot: sl};
    d.typed  = typed;
    d.answer = '{status: st, found_slot: fs, sector_out: so, free_count: fc};
    return d;
  endfunction

  // A name of random length: nonzero bytes, then, when shorter than twelve bytes, a
  // terminating zero and either garbage or zero padding, which the block must ignore.
  function automatic logic [NAME_W-1:0] random_name();
    logic [NAME_W-1:0] nm;
    int                len;
    bit                junk;
    nm   = '0;
    len  = ($urandom_range(3) == 0) ? 12 : $urandom_range(0, 12);
    junk = $urandom_range(1);
    for (int k = 0; k < 12; k++) begin
      if (k < len) nm[NAME_W-1-8*k -: 8] = 8'($urandom_range(1, 255));
      else if (k > len && junk) nm[NAME_W-1-8*k -: 8] = 8'($urandom_range(0, 255));
    end
    return nm;
  endfunction

  function automatic logic [15:0] random_sector();
    case ($urandom_range(15))
      0, 1:    return 16'h0000;
      2:       return 16'hFFFF;
      default: return 16'($urandom_range(1, 65535));
    endcase
  endfunction

  function automatic logic [2:0] pick_op();
    int p;
    p = $urandom_range(99);
    if (p < 30) return OP_LOOKUP;
    if (p < 55) return OP_ADD;
    if (p < 70) return OP_DELETE;
    if (p < 85) return OP_READ;
    if (p < 95) return OP_COUNT;
    return 3'($urandom_range(int'(OP_SPARE_FIRST), int'(OP_SPARE_LAST)));
  endfunction

  // Builds and sends one command of the given op with random content. Lookups
  // mostly reuse a name that was added earlier; a few use the empty name.
  task automatic send_random_op(input logic [2:0] o);
    command_t          c;
    logic [NAME_W-1:0] nm;
    int                p;
    p  = $urandom_range(99);
    nm = random_name();
    if (o == OP_LOOKUP && p < 70 && added_names.size() != 0) begin
      nm = added_names[$urandom_range(added_names.size() - 1)];
    end else if (o == OP_LOOKUP && p < 75) begin
      nm = '0;
    end
    if (o == OP_ADD) begin
      if (added_names.size() >= 48) added_names.delete($urandom_range(47));
      added_names.push_back(nm);
    end
    c.op                    = o;
    {c.name_high, c.name_low} = nm;
    c.sector                = random_sector();
    c.slot                  = 5'($urandom_range(31));
    send_command(c, 1'b0, '0);
  endtask

  // One random sequence: fill the table to the brim and past it, clear a run of
  // slots, or a single mixed command.
  task automatic run_sequence(output int sent);
    int pick;
    int guard;
    sent  = 0;
    guard = 0;
    pick  = $urandom_range(99);
    if (pick < 10) begin
      while (free_slots() > 0 && guard < 64) begin
        send_random_op(OP_ADD);
        guard++;
        sent++;
      end
      send_random_op(OP_ADD);
      sent++;
    end else if (pick < 20) begin
      repeat ($urandom_range(8, 24)) begin
        send_random_op(OP_DELETE);
        sent++;
      end
    end else begin
      send_random_op(pick_op());
      sent++;
    end
  endtask

  // Result side: check the beat taken at this edge, then choose the next ready.
  // A requested hold-off keeps ready low for a counted stretch so that the block
  // fills up and stalls its command input.
  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) begin
      results_seen++;
      if (owed_results.size() == 0) begin
        report_mismatch("beat with no command pending", 0, 0);
      end else begin
        oldest = owed_results.pop_front();
        if (status !== oldest.status) report_mismatch("status", status, oldest.status);
        if (found_slot !== oldest.found_slot) begin
          report_mismatch("found_slot", found_slot, oldest.found_slot);
        end
        if (sector_out !== oldest.sector_out) begin
          report_mismatch("sector_out", sector_out, oldest.sector_out);
        end
        if (free_count !== oldest.free_count) begin
          report_mismatch("free_count", free_count, oldest.free_count);
        end
      end
    end
    if (rst) begin
      res_ready <= 1'b0;
    end else if (hold_left > 0) begin
      res_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      res_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    int made;
    int got;
    for (int i = 0; i < ENTRIES; i++) begin
      name_tab[i]   = '0;
      sector_tab[i] = '0;
    end

    // Directed rows. Typed answers stand where they are plain: right after reset,
    // at the field extremes, and for the error codes. The rest use the predictor.
    directed_rows.push_back(row(OP_COUNT, '0, '0, '0, '0, 1'b1, ST_OK, 0, 0, 6'd32));
    // The empty key matches a cleared slot.
    directed_rows.push_back(row(OP_LOOKUP, '0, '0, '0, '0, 1'b1, ST_OK, 0, 0, 0));
    directed_rows.push_back(row(OP_READ, '0, '0, '0, 5'd31, 1'b1, ST_OK, 0, 0, 0));
    directed_rows.push_back(row(OP_ADD, '1, '1, 16'hFFFF, '0, 1'b1, ST_OK, 0, 0, 0));
    directed_rows.push_back(row(OP_LOOKUP, '1, '1, '0, '0, 1'b1, ST_OK, 0, 0, 0));
    directed_rows.push_back(row(OP_READ, '0, '0, '0, '0, 1'b1, ST_OK, 0, 16'hFFFF, 0));
    // Add with a zero sector writes the name but leaves slot 1 free.
    directed_rows.push_back(row(OP_ADD, 32'h54454D50, '0, '0, '0, 1'b1, ST_OK, 5'd1, 0, 0));
    directed_rows.push_back(row(OP_ADD, 32'h4B45524E, 64'h454C2E5359530000, 16'h0123, '0,
                                1'b0, ST_OK, 0, 0, 0));
    directed_rows.push_back(row(OP_LOOKUP, 32'h54454D50, '0, '0, '0, 1'b0, ST_OK, 0, 0, 0));
    // Garbage after the terminating zero byte must not matter.
    directed_rows.push_back(row(OP_LOOKUP, 32'h4B45524E, 64'h454C2E53595300FF, '0, '0,
                                1'b0, ST_OK, 0, 0, 0));
    directed_rows.push_back(row(OP_ADD, 32'h41005A5A, '1, 16'h0001, '0, 1'b0, ST_OK, 0, 0, 0));
    directed_rows.push_back(row(OP_LOOKUP, 32'h41000000, '0, '0, '0, 1'b0, ST_OK, 0, 0, 0));
    directed_rows.push_back(row(OP_COUNT, '0, '0, '0, '0, 1'b0, ST_OK, 0, 0, 0));
    directed_rows.push_back(row(OP_DELETE, '0, '0, '0, '0, 1'b1, ST_OK, 0, 0, 0));
    directed_rows.push_back(row(OP_READ, '0, '0, '0, '0, 1'b1, ST_OK, 0, 0, 0));
    directed_rows.push_back(row(OP_LOOKUP, '1, '1, '0, '0, 1'b1, ST_NOT_FOUND, 0, 0, 0));
    directed_rows.push_back(row(OP_LOOKUP, '0, '0, '0, '0, 1'b0, ST_OK, 0, 0, 0));
    directed_rows.push_back(row(OP_DELETE, '1, '1, '1, 5'd31, 1'b1, ST_OK, 0, 0, 0));
    directed_rows.push_back(row(OP_READ, '0, '0, '0, 5'd1, 1'b0, ST_OK, 0, 0, 0));
    // Unused op codes change nothing and answer with all zeros.
    directed_rows.push_back(row(OP_SPARE_FIRST, '1, '1, '1, '1, 1'b1, ST_OK, 0, 0, 0));
    directed_rows.push_back(row(OP_SPARE_LAST, '1, '1, '1, '1, 1'b1, ST_OK, 0, 0, 0));
    // A name whose first byte is zero is empty, whatever follows it.
    directed_rows.push_back(row(OP_ADD, 32'h00FFFFFF, '1, 16'hFFFF, '0, 1'b0, ST_OK, 0, 0, 0));
    directed_rows.push_back(row(OP_COUNT, '0, '0, '0, '0, 1'b0, ST_OK, 0, 0, 0));

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_command(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].answer);
    end
    drain_results();

    // Random phases: no idling, a mostly idle sender, a mostly stalling receiver,
    // light idling on both sides, and last a long receiver hold-off with the sender
    // pushing beats all the while. Each phase ends with the sender waiting for
    // every owed result.
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        1:       begin send_idle_pct = 86; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 86; end
        3:       begin send_idle_pct = 25; stall_pct = 25; end
        default: begin send_idle_pct = 0;  stall_pct = 0;  end
      endcase
      if (phase == PHASES - 1) hold_left = 300;
      made = 0;
      while (made < ITEMS_PER_PHASE) begin
        run_sequence(got);
        made += got;
      end
      drain_results();
    end

    // Let any late, unowed beat show up before the verdict.
    repeat (ENTRIES + 8) @(posedge clk);
    if (mismatches == 0) begin
      $display("file_directory_table_test passed");
    end else begin
      $display("file_directory_table_test failed");
    end
    $finish;
  end

  // Watchdog: a time limit far beyond the slowest correct run.
  initial begin
    #10_000_000;
    $display("file_directory_table_test failed");
    $finish;
  end

endmodule
